>>> rtl/core/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/core/md4f_pkg.sv
// Package for the folded MD4 one-way function: per-step constant tables,
// the round mixing function, the message word source and the cell payload type.
// No dependencies.
`timescale 1ns / 1ps

package md4f_pkg;

   localparam int NUM_STEPS = 48;

   // Chaining values at the start of the block.
   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;

   // Message word indexes that carry something other than zero.
   localparam logic [3:0] WIDX_KEY_LO = 4'd0;
   localparam logic [3:0] WIDX_KEY_HI = 4'd1;
   localparam logic [3:0] WIDX_PAD    = 4'd2;
   localparam logic [3:0] WIDX_LEN    = 4'd14;

   localparam logic [31:0] PAD_WORD = 32'h00000080;
   localparam logic [31:0] LEN_WORD = 32'd64;

   // Round codes.
   localparam logic [1:0] ROUND_F = 2'd0;
   localparam logic [1:0] ROUND_G = 2'd1;
   localparam logic [1:0] ROUND_H = 2'd2;

   localparam logic [3:0] WORD_ORDER [0:NUM_STEPS-1] = '{
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
      4'd0, 4'd4, 4'd8, 4'd12, 4'd1, 4'd5, 4'd9, 4'd13,
      4'd2, 4'd6, 4'd10, 4'd14, 4'd3, 4'd7, 4'd11, 4'd15,
      4'd0, 4'd8, 4'd4, 4'd12, 4'd2, 4'd10, 4'd6, 4'd14,
      4'd1, 4'd9, 4'd5, 4'd13, 4'd3, 4'd11, 4'd7, 4'd15
   };

   localparam logic [4:0] SHIFT_AMT [0:11] = '{
      5'd3, 5'd7, 5'd11, 5'd19,
      5'd3, 5'd5, 5'd9, 5'd13,
      5'd3, 5'd9, 5'd11, 5'd15
   };

   localparam logic [31:0] ADD_CONST [0:2] = '{
      32'h00000000, 32'h5A827999, 32'h6ED9EBA1
   };

   // Working state carried from one cell to the next, with the key riding along.
   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
      logic [63:0] key;
   } md4f_stage_type;

   function automatic logic [31:0] md4f_mix(input logic [1:0] round,
                                            input logic [31:0] x,
                                            input logic [31:0] y,
                                            input logic [31:0] z);
      logic [31:0] res;
      case (round)
         ROUND_F: res = (x & y) | (~x & z);
         ROUND_G: res = (x & y) | (x & z) | (y & z);
         default: res = x ^ y ^ z;
      endcase
      return res;
   endfunction

   // The padded block holds the key in words 0 and 1, the pad byte in word 2
   // and the bit length in word 14; every other word is zero.
   function automatic logic [31:0] md4f_msg_word(input logic [3:0] idx,
                                                 input logic [63:0] key);
      logic [31:0] res;
      case (idx)
         WIDX_KEY_LO: res = key[31:0];
         WIDX_KEY_HI: res = key[63:32];
         WIDX_PAD:    res = PAD_WORD;
         WIDX_LEN:    res = LEN_WORD;
         default:     res = 32'd0;
      endcase
      return res;
   endfunction

endpackage

>>> rtl/core/md4_fold_one_way_64.sv
// Channel   Ports                              Direction  Carries
// req       req_valid, req_stall, req_key_in    in         64-bit key, byte 0 lowest
// rsp       rsp_valid, rsp_stall, rsp_key_out   out        folded MD4 value, byte 0 lowest
//
// A row of 48 step cells, one per MD4 step, followed by a fold register.
// One key is taken per cycle while req_stall is low; results leave via the fold register.
// Reset clears only the valid bit of each cell and of the output register.
// A stalled result holds only the cells behind it that are full; empty cells
// keep filling, so keys are still taken until the row is full.
// Depends on md4f_pkg, md4f_cell and md4f_fold.
`timescale 1ns / 1ps

module md4_fold_one_way_64
   import md4f_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_key_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_key_out
);

   logic           valid [0:NUM_STEPS];
   md4f_stage_type data  [0:NUM_STEPS];
   logic           hold  [0:NUM_STEPS];

   assign valid[0]        = req_valid;
   assign data[0]         = {INIT_A, INIT_B, INIT_C, INIT_D, req_key_in};
   assign req_stall       = hold[0];

   for (genvar g = 0; g < NUM_STEPS; g++) begin : g_cell
      md4f_cell #(
         .STEP(g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (valid[g]),
         .in_data  (data[g]),
         .in_hold  (hold[g]),
         .out_valid(valid[g+1]),
         .out_data (data[g+1]),
         .out_hold (hold[g+1])
      );
   end

   md4f_fold u_fold (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (valid[NUM_STEPS]),
      .in_data    (data[NUM_STEPS]),
      .in_hold    (hold[NUM_STEPS]),
      .rsp_valid  (rsp_valid),
      .rsp_key_out(rsp_key_out),
      .rsp_stall  (rsp_stall)
   );

endmodule

>>> rtl/core/md4f_cell.sv
// One MD4 step cell: applies step STEP to the incoming state and registers it.
// Depends on md4f_pkg for the step tables, the mixing function and the payload type.
`timescale 1ns / 1ps

module md4f_cell
   import md4f_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  md4f_stage_type in_data,
   output logic           in_hold,
   output logic           out_valid,
   output md4f_stage_type out_data,
   input  logic           out_hold
);

   localparam int          RIDX  = STEP / 16;
   localparam logic [1:0]  ROUND = 2'(RIDX);
   localparam int          SIDX  = RIDX * 4 + STEP % 4;
   localparam logic [4:0]  SHAMT = SHIFT_AMT[SIDX];
   localparam logic [4:0]  RSHAMT = 5'(32 - SHAMT);
   localparam logic [3:0]  WIDX  = WORD_ORDER[STEP];
   localparam logic [31:0] KADD  = ADD_CONST[RIDX];

   logic           valid_ff, valid_in;
   md4f_stage_type data_ff, data_in;
   logic           hold;
   logic [31:0]    sum;
   logic [31:0]    rot;

   // The cell keeps its contents only while it is full and the next one holds.
   assign hold    = valid_ff & out_hold;
   assign in_hold = hold;

   always_comb begin
      sum = in_data.a + md4f_mix(ROUND, in_data.b, in_data.c, in_data.d)
            + md4f_msg_word(WIDX, in_data.key) + KADD;
      rot = (sum << SHAMT) | (sum >> RSHAMT);
      // Roles shift by one word per step, so after every four steps the
      // words are back in their original positions.
      data_in.a   = in_data.d;
      data_in.b   = rot;
      data_in.c   = in_data.b;
      data_in.d   = in_data.c;
      data_in.key = in_data.key;
      valid_in    = hold ? valid_ff : in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/core/md4f_fold.sv
// Output stage: adds the initial chaining values, folds the digest to 64 bits
// and holds the result for the response channel. Depends on md4f_pkg.
`timescale 1ns / 1ps

module md4f_fold
   import md4f_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  md4f_stage_type in_data,
   output logic           in_hold,
   output logic           rsp_valid,
   output logic [63:0]    rsp_key_out,
   input  logic           rsp_stall
);

   logic        valid_ff, valid_in;
   logic [63:0] key_ff, key_in;
   logic        hold;
   logic [31:0] fa, fb, fc, fd;

   assign hold    = valid_ff & rsp_stall;
   assign in_hold = hold;

   always_comb begin
      fa       = in_data.a + INIT_A;
      fb       = in_data.b + INIT_B;
      fc       = in_data.c + INIT_C;
      fd       = in_data.d + INIT_D;
      key_in   = {fb ^ fd, fa ^ fc};
      valid_in = hold ? valid_ff : in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold) begin
         key_ff <= key_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_key_out = key_ff;

endmodule

>>> rtl/core/md4f_checker.sv
// Port-level checks for md4_fold_one_way_64, attached by the bind below.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module md4f_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [63:0] req_key_in,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_key_out
);

   // A stalled request keeps its key and stays offered.
   `CHK_NEXT(a_req_hold, clock, reset, req_valid && req_stall, req_valid && $stable(req_key_in))

   // A stalled result keeps its value and stays offered.
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_key_out))

   // Reset leaves no result behind.
   `CHK_IMPLY(a_rsp_reset, clock, reset, $past(reset), !rsp_valid)

   // With the output register free, every cell can move, so keys are taken.
   `CHK_IMPLY(a_req_free_empty, clock, reset, !rsp_valid, !req_stall)

   // A consumer that never stalls never pushes back onto the requester.
   `CHK_IMPLY(a_req_free_flow, clock, reset, !rsp_stall, !req_stall)

endmodule

bind md4_fold_one_way_64 md4f_checker u_md4f_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .req_key_in (req_key_in),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_key_out(rsp_key_out)
);

>>> dv/md4_fold_one_way_64_checker.sv
// Checker for md4_fold_one_way_64: watches both channels, predicts the folded MD4 value
// of every accepted key and compares each result transaction against it in order.
// Standalone; needs only the channel signals of the block.
`timescale 1ns / 1ps

module md4_fold_one_way_64_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [63:0] req_key_in,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [63:0] rsp_key_out,
   output int          fail_count,
   output int          outstanding,
   output int          digests_checked
);

   typedef enum logic [1:0] {RND_F, RND_G, RND_H} md4_round_type;

   localparam logic [31:0] CHAIN_A = 32'h67452301;
   localparam logic [31:0] CHAIN_B = 32'hefcdab89;
   localparam logic [31:0] CHAIN_C = 32'h98badcfe;
   localparam logic [31:0] CHAIN_D = 32'h10325476;

   localparam logic [31:0] ROUND_ADD [3] = '{32'h00000000, 32'h5A827999, 32'h6ED9EBA1};
   localparam int          ROT_BY [12]   = '{3, 7, 11, 19, 3, 5, 9, 13, 3, 9, 11, 15};

   logic [63:0] digest_q [$];

   function automatic logic [31:0] boolean_mix(input md4_round_type rnd, input logic [31:0] x,
                                               input logic [31:0] y, input logic [31:0] z);
      case (rnd)
         RND_F:   return (x & y) | (~x & z);
         RND_G:   return (x & y) | (x & z) | (y & z);
         default: return x ^ y ^ z;
      endcase
   endfunction

   // One padded block: the key in words 0 and 1, the 0x80 pad byte in word 2
   // and the 64-bit message length in word 14.
   function automatic logic [63:0] fold_md4(input logic [63:0] key);
      logic [31:0]   msg [16];
      logic [31:0]   st [4];
      logic [31:0]   sum;
      logic [3:0]    j;
      logic [3:0]    w;
      logic [1:0]    t;
      md4_round_type rnd;
      int            s;
      foreach (msg[k]) msg[k] = 32'd0;
      msg[0]  = key[31:0];
      msg[1]  = key[63:32];
      msg[2]  = 32'h00000080;
      msg[14] = 32'd64;
      st = '{CHAIN_A, CHAIN_B, CHAIN_C, CHAIN_D};
      for (int i = 0; i < 48; i++) begin
         rnd = md4_round_type'(i / 16);
         j   = 4'(i % 16);
         // The second round walks the words column-wise, the third in bit-reversed order.
         case (rnd)
            RND_F:   w = j;
            RND_G:   w = {j[1:0], j[3:2]};
            default: w = {j[0], j[1], j[2], j[3]};
         endcase
         t   = 2'(4 - (i % 4));
         sum = st[t] + boolean_mix(rnd, st[2'(t + 1)], st[2'(t + 2)], st[2'(t + 3)])
               + msg[w] + ROUND_ADD[rnd];
         s   = ROT_BY[4 * int'(rnd) + i % 4];
         st[t] = (sum << s) | (sum >> (32 - s));
      end
      st[0] += CHAIN_A;
      st[1] += CHAIN_B;
      st[2] += CHAIN_C;
      st[3] += CHAIN_D;
      return {st[1] ^ st[3], st[0] ^ st[2]};
   endfunction

   initial begin
      fail_count      = 0;
      outstanding     = 0;
      digests_checked = 0;
   end

   always @(posedge clock) begin
      logic [63:0] want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (digest_q.size() == 0) begin
               $error("rsp_key_out: unexpected transaction %h with nothing outstanding",
                      rsp_key_out);
               fail_count++;
            end else begin
               want = digest_q.pop_front();
               digests_checked++;
               if (rsp_key_out !== want) begin
                  $error("rsp_key_out mismatch: expected %h, actual %h", want, rsp_key_out);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            digest_q.push_back(fold_md4(req_key_in));
         outstanding <= digest_q.size();
      end
   end

endmodule

>>> dv/md4_fold_one_way_64_tb.sv
// Top of the md4_fold_one_way_64 testbench: clock, reset, key stimulus, output stall
// pattern and the verdict. Depends on md4_fold_one_way_64 and md4_fold_one_way_64_checker.
`timescale 1ns / 1ps

module md4_fold_one_way_64_tb;

   localparam int RANDOM_KEYS  = 1500;
   localparam int HOLD_CYCLES  = 150;
   localparam int DRAIN_CYCLES = 60;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic [63:0] req_key_in  = 64'd0;
   logic        rsp_stall   = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic [63:0] rsp_key_out;

   logic quiet     = 1'b0;
   logic hold_req  = 1'b0;
   logic hold_done = 1'b0;

   int fail_count;
   int outstanding;
   int digests_checked;
   int keys_sent = 0;
   int directed_keys = 0;

   md4_fold_one_way_64 dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_key_in  (req_key_in),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_key_out (rsp_key_out)
   );

   md4_fold_one_way_64_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_key_in      (req_key_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_key_out     (rsp_key_out),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .digests_checked (digests_checked)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Offers one key and returns at the edge where the transaction completes.
   task automatic offer_key(input logic [63:0] key);
      int gap;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_key_in <= key;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      keys_sent++;
   endtask

   task automatic wait_until_empty();
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Mostly uniform keys, with single-bit, single-hole and repeated-byte patterns mixed in.
   function automatic logic [63:0] pick_key();
      logic [63:0] k;
      logic [7:0]  b;
      b = 8'($urandom);
      case ($urandom_range(0, 9))
         0:       k = 64'd1 << $urandom_range(0, 63);
         1:       k = ~(64'd1 << $urandom_range(0, 63));
         2:       k = {8{b}};
         default: k = {$urandom(), $urandom()};
      endcase
      return k;
   endfunction

   // Output side: short random stall bursts, plus one long hold on request.
   initial begin : rsp_side
      int burst;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_req && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_done = 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 3);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      logic [63:0] corner_keys [$];
      corner_keys = '{
         64'h0000000000000000, 64'hFFFFFFFFFFFFFFFF, 64'h0000000000000001,
         64'h8000000000000000, 64'h00000000FFFFFFFF, 64'hFFFFFFFF00000000,
         64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA, 64'h0123456789ABCDEF,
         64'hFEDCBA9876543210, 64'h0706050403020100, 64'h0000000080000000,
         64'h0000000100000000, 64'h7FFFFFFFFFFFFFFF, 64'h00000000000000FF,
         64'hFF00000000000000
      };
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (corner_keys[i]) offer_key(corner_keys[i]);
      directed_keys = corner_keys.size();

      for (int n = 0; n < RANDOM_KEYS; n++) begin
         if (n == 300)
            hold_req <= 1'b1;
         if (n == 800) begin
            req_valid <= 1'b0;
            wait_until_empty();
         end
         if (n == RANDOM_KEYS - 200)
            quiet <= 1'b1;
         offer_key(pick_key());
      end
      req_valid <= 1'b0;

      wait_until_empty();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Hashed %0d keys (%0d corner patterns), compared %0d digests,",
               keys_sent, directed_keys, digests_checked);
      $display("including a %0d-cycle output hold and a full drain mid-run.", HOLD_CYCLES);
      if (fail_count == 0 && outstanding == 0) begin
         $display("md4_fold_one_way_64_tb: PASS");
      end else begin
         $display("md4_fold_one_way_64_tb: FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #400000;
      $display("Run timed out with %0d digests outstanding.", outstanding);
      $display("md4_fold_one_way_64_tb: FAIL");
      $finish;
   end

endmodule
